>>> design/sedd_pkg.sv
`default_nettype none
package sedd_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int ERR_W     = 9;
   localparam int LEVEL_W   = 4;
   localparam int FWIDTH_W  = 13;
   localparam int FHEIGHT_W = 16;
   localparam int PADDR_W   = 4;
   localparam int RECIP_W   = 26;
   localparam int RECIP_SH  = 25;

   localparam logic [FWIDTH_W-1:0] WIDTH_MAX = FWIDTH_W'(MAX_WIDTH);

   // diffusion weights, sixteenths
   localparam logic [2:0] W_AHEAD  = 3'd1;
   localparam logic [2:0] W_ABOVE  = 3'd5;
   localparam logic [2:0] W_BEHIND = 3'd3;
   localparam logic [2:0] W_CARRY  = 3'd7;

   typedef enum logic [1:0] {
      CSR_LEVEL_BITS   = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2,
      CSR_NONE         = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HERE,
      ST_DIFFUSE,
      ST_QUANT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   level_bits;
      logic [FWIDTH_W-1:0]  frame_width;
      logic [FHEIGHT_W-1:0] frame_height;
   } cfg_type;

   // v + trunc(e*num/16), clamped to 0..255
   function automatic logic [7:0] diffuse(input logic [7:0] v,
                                          input logic signed [ERR_W-1:0] e,
                                          input logic [2:0] num);
      logic signed [12:0] p;
      logic signed [12:0] s;
      logic signed [12:0] r;
      p = $signed({{4{e[ERR_W-1]}}, e}) * $signed({10'd0, num});
      if (p[12]) begin
         p = p + 13'sd15;
      end
      s = p >>> 4;
      r = $signed({5'd0, v}) + s;
      if (r[12]) begin
         diffuse = 8'd0;
      end else if (r > 13'sd255) begin
         diffuse = 8'd255;
      end else begin
         diffuse = r[7:0];
      end
   endfunction

   function automatic logic [LEVEL_W-1:0] clamp_bits(input logic [LEVEL_W-1:0] b);
      if (b == '0) begin
         clamp_bits = LEVEL_W'(1);
      end else if (b > LEVEL_W'(8)) begin
         clamp_bits = LEVEL_W'(8);
      end else begin
         clamp_bits = b;
      end
   endfunction

   // levels minus one
   function automatic logic [7:0] level_mask(input logic [LEVEL_W-1:0] b);
      logic [8:0] t;
      t = (9'd1 << b) - 9'd1;
      level_mask = t[7:0];
   endfunction

   // ceil(2^25 / (2^b - 1))
   function automatic logic [RECIP_W-1:0] level_recip(input logic [LEVEL_W-1:0] b);
      case (b)
         LEVEL_W'(1): level_recip = RECIP_W'(33554432);
         LEVEL_W'(2): level_recip = RECIP_W'(11184811);
         LEVEL_W'(3): level_recip = RECIP_W'(4793491);
         LEVEL_W'(4): level_recip = RECIP_W'(2236963);
         LEVEL_W'(5): level_recip = RECIP_W'(1082402);
         LEVEL_W'(6): level_recip = RECIP_W'(532611);
         LEVEL_W'(7): level_recip = RECIP_W'(264209);
         default:     level_recip = RECIP_W'(131587);
      endcase
   endfunction

endpackage
`default_nettype wire

>>> design/sedd_ram.sv
`default_nettype none
module sedd_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/sedd_csr.sv
`default_nettype none
module sedd_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sedd_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready,
   output sedd_pkg::cfg_type                 cfg
);
   import sedd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_fire;

   assign pready  = 1'b1;
   assign index   = csr_index_type'(paddr[PADDR_W-1:2]);
   assign wr_fire = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (index)
            CSR_LEVEL_BITS:   cfg_in.level_bits   = pwdata[LEVEL_W-1:0];
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = pwdata[FWIDTH_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = pwdata[FHEIGHT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_bits   <= LEVEL_W'(1);
         cfg_ff.frame_width  <= FWIDTH_W'(640);
         cfg_ff.frame_height <= FHEIGHT_W'(480);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         CSR_LEVEL_BITS:   prdata = {{(32-LEVEL_W){1'b0}}, cfg_ff.level_bits};
         CSR_FRAME_WIDTH:  prdata = {{(32-FWIDTH_W){1'b0}}, cfg_ff.frame_width};
         CSR_FRAME_HEIGHT: prdata = {{(32-FHEIGHT_W){1'b0}}, cfg_ff.frame_height};
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> design/sedd_quant.sv
`default_nettype none
module sedd_quant (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic [7:0]                   value,
   input  wire logic [sedd_pkg::LEVEL_W-1:0] bits,
   output logic      [7:0]                   level
);
   import sedd_pkg::*;

   logic [7:0]         mask;
   logic [15:0]        scaled;
   logic [15:0]        div_sum;
   logic [7:0]         index_in;
   logic [7:0]         index_ff;
   logic [15:0]        numer;
   logic [41:0]        prod;

   assign mask = level_mask(bits);

   // stage 1: index = (v*m + 127) / 255, divide by 255 as add-and-shift
   assign scaled   = {8'd0, value} * {8'd0, mask} + 16'd127;
   assign div_sum  = scaled + {8'd0, scaled[15:8]} + 16'd1;
   assign index_in = div_sum[15:8];

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= index_in;
      end
   end

   // stage 2: (index*255 + m/2) / m through a reciprocal
   assign numer = {index_ff, 8'd0} - {8'd0, index_ff} + {9'd0, mask[7:1]};
   assign prod  = 42'(numer) * 42'(level_recip(bits));
   assign level = prod[RECIP_SH+7:RECIP_SH];

endmodule
`default_nettype wire

>>> design/serpentine_error_diffusion_dither_unit.sv
`default_nettype none
// Serpentine Floyd-Steinberg dither for 8-bit gray frames, one output pixel per input
// pixel in visiting order (even rows left to right, odd rows right to left). A pixel
// passes ST_DIFFUSE, ST_QUANT and ST_DONE, where its result is registered; a new pixel
// is taken only in ST_IDLE, and ST_HERE comes first when the previous-row error of its
// own column is not already held in the cached line-memory entry (only after the frame
// geometry is changed mid-frame). The error loop sets this pace: a pixel's error feeds
// the next pixel's diffusion through the two-stage quantizer, and the single read port
// of the error line memory fetches one entry per cycle. The result register lets the
// next pixel be taken while a result waits; that pixel then holds in its last cycle
// until the register drains. The line memory needs no clearing after reset.
module serpentine_error_diffusion_dither_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_pixel_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [7:0]                   rsp_pixel_out,
   output logic                              rsp_end_of_row,
   output logic                              rsp_end_of_frame,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sedd_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready
);
   import sedd_pkg::*;

   cfg_type cfg;

   state_type state_ff, state_in;

   // geometry of the pixel in flight
   logic [FWIDTH_W-1:0]  w_eff;
   logic [ADDR_W-1:0]    w_m1;
   logic [FHEIGHT_W-1:0] h_m1;
   logic [ADDR_W-1:0]    pos_c;
   logic [FHEIGHT_W-1:0] row_c;
   logic [ADDR_W-1:0]    x_c, nx_c;
   logic                 hit_c, need_here_c;

   logic [ADDR_W-1:0]    col_ff, col_in;
   logic [FHEIGHT_W-1:0] row_ff, row_in;
   logic [FHEIGHT_W-1:0] cur_row_ff;
   logic [ADDR_W-1:0]    x_ff, nx_ff;
   logic                 first_ff, last_col_ff, last_row_ff;
   logic [7:0]           pixel_ff;
   logic [7:0]           v_ff, v_in;

   // errors
   logic signed [ERR_W-1:0] carry_ff, passed_ff, cur_here_ff;
   logic signed [ERR_W-1:0] cache_ff;
   logic [ADDR_W-1:0]       tag_ff;
   logic                    tag_valid_ff;
   logic signed [ERR_W-1:0] err;

   // memory
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ERR_W-1:0]  ram_rd_data;

   logic       accept, slot_free, finish, quant_load;
   logic [7:0] q;
   logic [LEVEL_W-1:0] bits_eff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_pixel_ff;
   logic       rsp_eor_ff, rsp_eof_ff;

   sedd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sedd_ram #(
      .WIDTH (ERR_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (x_ff),
      .wr_data (err),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign bits_eff = clamp_bits(cfg.level_bits);

   sedd_quant u_quant (
      .clock (clock),
      .load  (quant_load),
      .value (v_ff),
      .bits  (bits_eff),
      .level (q)
   );

   // geometry, clamped to the current frame size
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = FWIDTH_W'(1);
      end else if (cfg.frame_width > WIDTH_MAX) begin
         w_eff = WIDTH_MAX;
      end else begin
         w_eff = cfg.frame_width;
      end
      w_m1 = ADDR_W'(w_eff - FWIDTH_W'(1));
      h_m1 = (cfg.frame_height == '0) ? '0 : cfg.frame_height - FHEIGHT_W'(1);
      pos_c = (col_ff > w_m1) ? w_m1 : col_ff;
      row_c = (row_ff > h_m1) ? h_m1 : row_ff;
      x_c  = row_c[0] ? (w_m1 - pos_c) : pos_c;
      nx_c = row_c[0] ? (x_c - ADDR_W'(1)) : (x_c + ADDR_W'(1));
      hit_c = tag_valid_ff && (tag_ff == x_c);
      need_here_c = (row_c != '0) && !hit_c;
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_DONE) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = need_here_c ? ST_HERE : ST_DIFFUSE;
            end
         end
         ST_HERE:    state_in = ST_DIFFUSE;
         ST_DIFFUSE: state_in = ST_QUANT;
         ST_QUANT:   state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      quant_load  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_addr = nx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ram_rd_addr = need_here_c ? x_c : nx_c;
         end
         ST_HERE:    ram_rd_addr = nx_ff;
         ST_DIFFUSE: ram_rd_addr = nx_ff;
         ST_QUANT:   quant_load  = 1'b1;
         ST_DONE:    ram_wr_en   = slot_free;
         default:    ram_rd_addr = nx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // diffusion chain; ram_rd_data holds the entry ahead of this pixel
   always_comb begin
      v_in = pixel_ff;
      if (cur_row_ff != '0) begin
         if (!last_col_ff) begin
            v_in = diffuse(v_in, $signed(ram_rd_data), W_AHEAD);
         end
         v_in = diffuse(v_in, cache_ff, W_ABOVE);
         if (!first_ff) begin
            v_in = diffuse(v_in, passed_ff, W_BEHIND);
         end
      end
      if (!first_ff) begin
         v_in = diffuse(v_in, carry_ff, W_CARRY);
      end
   end

   assign err = $signed({1'b0, v_ff}) - $signed({1'b0, q});

   // pixel registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff    <= req_pixel_in;
         cur_row_ff  <= row_c;
         x_ff        <= x_c;
         nx_ff       <= nx_c;
         first_ff    <= (pos_c == '0);
         last_col_ff <= (pos_c == w_m1);
         last_row_ff <= (row_c == h_m1);
      end
      if (state_ff == ST_DIFFUSE) begin
         v_ff        <= v_in;
         cur_here_ff <= cache_ff;
      end
   end

   // position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (finish) begin
         if (last_col_ff) begin
            col_in = '0;
            row_in = last_row_ff ? '0 : cur_row_ff + FHEIGHT_W'(1);
         end else begin
            col_in = col_ff + ADDR_W'(1);
            row_in = cur_row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         carry_ff  <= '0;
         passed_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (finish) begin
            carry_ff  <= last_col_ff ? '0 : err;
            passed_ff <= last_col_ff ? '0 : cur_here_ff;
         end
      end
   end

   // one cached line entry, kept equal to the memory at its tag
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_HERE: begin
               cache_ff     <= $signed(ram_rd_data);
               tag_ff       <= x_ff;
               tag_valid_ff <= 1'b1;
            end
            ST_DIFFUSE: begin
               cache_ff     <= $signed(ram_rd_data);
               tag_ff       <= nx_ff;
               tag_valid_ff <= !last_col_ff;
            end
            ST_DONE: begin
               if (slot_free) begin
                  if (last_col_ff) begin
                     cache_ff     <= err;
                     tag_ff       <= x_ff;
                     tag_valid_ff <= 1'b1;
                  end else if (tag_valid_ff && (tag_ff == x_ff)) begin
                     cache_ff <= err;
                  end
               end
            end
            default: tag_valid_ff <= tag_valid_ff;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_pixel_ff <= q;
         rsp_eor_ff   <= last_col_ff;
         rsp_eof_ff   <= last_col_ff && last_row_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sedd_pkg::*;

   typedef struct packed {
      logic [7:0] pixel;
      logic       eor;
      logic       eof;
   } dithered_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_pixel_in = 8'd0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [7:0]          rsp_pixel_out;
   logic                rsp_end_of_row;
   logic                rsp_end_of_frame;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   serpentine_error_diffusion_dither_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // dither state mirrored by the testbench
   logic [LEVEL_W-1:0]      cfg_level  = LEVEL_W'(1);
   logic [FWIDTH_W-1:0]     cfg_width  = FWIDTH_W'(640);
   logic [FHEIGHT_W-1:0]    cfg_height = FHEIGHT_W'(480);
   int                      col_pos    = 0;
   int                      row_pos    = 0;
   int                      carry_err  = 0;
   int                      passed_err = 0;
   bit signed [ERR_W-1:0]   row_err     [MAX_WIDTH];
   bit                      col_written [MAX_WIDTH];

   dithered_type pending_pixels[$];
   int        errors        = 0;
   int        gap_pct       = 0;
   int        stall_pct     = 0;
   int        hold_request  = 0;
   int        hold_left     = 0;

   function automatic int spread(input int v, input int e, input int num);
      int r;
      r = v + (e * num) / 16;
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return r;
   endfunction

   function automatic int quantize_level(input int v);
      int bits;
      int m;
      int n;
      bits = cfg_level;
      if (bits < 1) bits = 1;
      if (bits > 8) bits = 8;
      m = (1 << bits) - 1;
      n = (v * m + 127) / 255;
      return (n * 255 + m / 2) / m;
   endfunction

   function automatic int eff_width(input logic [FWIDTH_W-1:0] wd);
      if (wd == 0) return 1;
      if (wd > MAX_WIDTH) return MAX_WIDTH;
      return wd;
   endfunction

   function automatic dithered_type dither_pixel(input logic [7:0] pix);
      int        w;
      int        h;
      int        pos;
      int        row;
      int        x;
      int        nx;
      int        v;
      int        q;
      int        err;
      int        here;
      bit        rev;
      bit        first_px;
      bit        last_col;
      bit        last_row;
      dithered_type res;
      w = eff_width(cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      pos = (col_pos >= w) ? w - 1 : col_pos;
      row = (row_pos >= h) ? h - 1 : row_pos;
      rev = (row % 2) != 0;
      x = rev ? (w - 1 - pos) : pos;
      first_px = (pos == 0);
      last_col = (pos == w - 1);
      last_row = (row == h - 1);
      v = pix;
      here = row_err[x];
      if (row > 0) begin
         if (!last_col) begin
            nx = rev ? x - 1 : x + 1;
            v = spread(v, row_err[nx], int'(W_AHEAD));
         end
         v = spread(v, here, int'(W_ABOVE));
         if (!first_px) v = spread(v, passed_err, int'(W_BEHIND));
      end
      if (!first_px) v = spread(v, carry_err, int'(W_CARRY));
      q = quantize_level(v);
      err = v - q;
      passed_err = here;
      row_err[x] = ERR_W'(err);
      col_written[x] = 1'b1;
      carry_err = err;
      res.pixel = q[7:0];
      res.eor = last_col;
      res.eof = last_col && last_row;
      if (last_col) begin
         col_pos = 0;
         carry_err = 0;
         passed_err = 0;
         row_pos = last_row ? 0 : row + 1;
      end else begin
         col_pos = pos + 1;
         row_pos = row;
      end
      return res;
   endfunction

   // a width is only allowed mid-frame if every column it reads back holds an error
   function automatic logic [FWIDTH_W-1:0] safe_width(input logic [FWIDTH_W-1:0] wd,
                                                     input logic [FHEIGHT_W-1:0] ht);
      int h_eff;
      int row_eff;
      int filled;
      h_eff = (ht == 0) ? 1 : ht;
      row_eff = (row_pos >= h_eff) ? h_eff - 1 : row_pos;
      filled = 0;
      while (filled < MAX_WIDTH && col_written[filled]) filled++;
      if (row_eff == 0 || eff_width(wd) <= filled) return wd;
      return FWIDTH_W'(filled);
   endfunction

   function automatic logic [7:0] random_pixel();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) return 8'($urandom);
      if (sel < 60) return 8'd0;
      if (sel < 75) return 8'd255;
      return 8'($urandom_range(136, 120));
   endfunction

   // result checker
   always @(posedge clock) begin
      dithered_type exp_px;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected transfer, pixel_out %0d eor %0b eof %0b", $time,
                     rsp_pixel_out, rsp_end_of_row, rsp_end_of_frame);
            errors++;
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp_pixel_out !== exp_px.pixel) begin
               $display("%0t: pixel_out expected %0d, got %0d", $time, exp_px.pixel,
                        rsp_pixel_out);
               errors++;
            end
            if (rsp_end_of_row !== exp_px.eor) begin
               $display("%0t: end_of_row expected %0b, got %0b", $time, exp_px.eor,
                        rsp_end_of_row);
               errors++;
            end
            if (rsp_end_of_frame !== exp_px.eof) begin
               $display("%0t: end_of_frame expected %0b, got %0b", $time, exp_px.eof,
                        rsp_end_of_frame);
               errors++;
            end
         end
      end
   end

   // receiver stalls and long hold-offs
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // valid stays high between back-to-back pixels; it only drops for a gap
   task automatic push_pixel(input logic [7:0] pix);
      dithered_type exp_px;
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         req_pixel_in <= 8'($urandom);
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      exp_px = dither_pixel(pix);
      pending_pixels = {pending_pixels, exp_px};
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] readback_exp;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_LEVEL_BITS: begin
            cfg_level = value[LEVEL_W-1:0];
            readback_exp = 32'(cfg_level);
         end
         CSR_FRAME_WIDTH: begin
            cfg_width = value[FWIDTH_W-1:0];
            readback_exp = 32'(cfg_width);
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = value[FHEIGHT_W-1:0];
            readback_exp = 32'(cfg_height);
         end
         default: readback_exp = '0;
      endcase
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== readback_exp) begin
         $display("%0t: %s readback expected %0h, got %0h", $time, idx.name(),
                  readback_exp, prdata);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_reconfig();
      logic [LEVEL_W-1:0]   lvl;
      logic [FWIDTH_W-1:0]  wd;
      logic [FHEIGHT_W-1:0] ht;
      bit                   do_lvl;
      bit                   do_wd;
      bit                   do_ht;
      int                   sel;
      do_lvl = $urandom_range(99) < 60;
      do_wd = $urandom_range(99) < 60;
      do_ht = $urandom_range(99) < 60;
      if (!do_lvl && !do_wd && !do_ht) do_lvl = 1'b1;
      lvl = ($urandom_range(99) < 85) ? LEVEL_W'($urandom_range(8, 1)) : LEVEL_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 70) wd = FWIDTH_W'($urandom_range(8, 1));
      else if (sel < 90) wd = FWIDTH_W'($urandom_range(40, 9));
      else if (sel < 97) wd = '0;
      else wd = FWIDTH_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 70) ht = FHEIGHT_W'($urandom_range(6, 1));
      else if (sel < 85) ht = '0;
      else ht = FHEIGHT_W'($urandom);
      if (!do_lvl) lvl = cfg_level;
      if (!do_wd) wd = cfg_width;
      if (!do_ht) ht = cfg_height;
      if (safe_width(wd, ht) != wd) begin
         wd = safe_width(wd, ht);
         do_wd = 1'b1;
      end
      if (do_lvl) csr_write(CSR_LEVEL_BITS, 32'(lvl));
      if (do_wd) csr_write(CSR_FRAME_WIDTH, 32'(wd));
      if (do_ht) csr_write(CSR_FRAME_HEIGHT, 32'(ht));
   endtask

   task automatic test_reset_defaults();
      gap_pct = 0;
      stall_pct = 0;
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_pixel(8'd128);
      push_pixel(8'd127);
      push_pixel(8'd255);
      wait_for_results();
   endtask

   // width shrinks under the current column, so the first pixel closes row 0
   task automatic test_frame_edges();
      csr_write(CSR_LEVEL_BITS, 32'd8);
      csr_write(CSR_FRAME_WIDTH, 32'd3);
      csr_write(CSR_FRAME_HEIGHT, 32'd3);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd255);
      wait_for_results();
      csr_write(CSR_LEVEL_BITS, 32'd1);
      csr_write(CSR_FRAME_WIDTH, 32'd2);
      csr_write(CSR_FRAME_HEIGHT, 32'd2);
      push_pixel(8'd128);
      push_pixel(8'd127);
      push_pixel(8'd127);
      push_pixel(8'd128);
      wait_for_results();
   endtask

   task automatic test_register_extremes();
      csr_write(CSR_LEVEL_BITS, 32'd0);
      csr_write(CSR_FRAME_WIDTH, 32'd0);
      csr_write(CSR_FRAME_HEIGHT, 32'd0);
      push_pixel(8'd0);
      push_pixel(8'd255);
      wait_for_results();
      csr_write(CSR_LEVEL_BITS, 32'd15);
      csr_write(CSR_FRAME_WIDTH, 32'd1);
      csr_write(CSR_FRAME_HEIGHT, 32'd1);
      push_pixel(8'd200);
      push_pixel(8'd55);
      wait_for_results();
      csr_write(CSR_LEVEL_BITS, 32'd9);
      csr_write(CSR_FRAME_WIDTH, 32'd5);
      push_pixel(8'd255);
      push_pixel(8'd0);
      push_pixel(8'd129);
      push_pixel(8'd126);
      push_pixel(8'd255);
      wait_for_results();
   endtask

   // oversized width acts as the line memory depth, so no row ends here
   task automatic test_widest_row();
      gap_pct = 0;
      stall_pct = 0;
      csr_write(CSR_LEVEL_BITS, 32'd8);
      csr_write(CSR_FRAME_WIDTH, 32'h1FFF);
      csr_write(CSR_FRAME_HEIGHT, 32'd2);
      repeat (64) push_pixel(random_pixel());
      wait_for_results();
   endtask

   task automatic test_tall_frame();
      gap_pct = 30;
      stall_pct = 30;
      csr_write(CSR_LEVEL_BITS, 32'd3);
      csr_write(CSR_FRAME_WIDTH, 32'd3);
      csr_write(CSR_FRAME_HEIGHT, 32'hFFFF);
      repeat (36) push_pixel(random_pixel());
      wait_for_results();
   endtask

   // long receiver hold-offs with the sender still pushing, each followed by a full drain
   task automatic test_backpressure();
      gap_pct = 0;
      stall_pct = 0;
      csr_write(CSR_LEVEL_BITS, 32'd2);
      csr_write(CSR_FRAME_WIDTH, 32'd7);
      csr_write(CSR_FRAME_HEIGHT, 32'd4);
      hold_request = 60;
      repeat (20) push_pixel(random_pixel());
      wait_for_results();
      gap_pct = 20;
      hold_request = 40;
      repeat (20) push_pixel(random_pixel());
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int gap, input int stall, input int count);
      int sent;
      int seg;
      gap_pct = gap;
      stall_pct = stall;
      sent = 0;
      while (sent < count) begin
         seg = $urandom_range(50, 15);
         repeat (seg) push_pixel(random_pixel());
         sent += seg;
         wait_for_results();
         random_reconfig();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_frame_edges();
      test_register_extremes();
      test_widest_row();
      test_tall_frame();
      test_backpressure();
      test_random_traffic(0, 0, 120);
      test_random_traffic(74, 0, 120);
      test_random_traffic(0, 74, 120);
      test_random_traffic(9, 9, 120);
      wait_for_results();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
